// File: hw/rtl/crng_pkg.sv
// Shared constants, command and status types for the combined LCG shuffle generator.
package crng_pkg;

    // Word width of generator states and results
    localparam int unsigned WORD_W = 31;

    // Input function codes
    localparam logic FUNC_DRAW   = 1'b0;
    localparam logic FUNC_RESEED = 1'b1;

    // Moduli, multipliers and reset state of the two congruential generators
    localparam logic [31:0] MOD_A       = 32'd2147483563;
    localparam logic [31:0] MOD_B       = 32'd2147483399;
    localparam logic [15:0] MUL_A       = 16'd40014;
    localparam logic [15:0] MUL_B       = 16'd40692;
    localparam logic [30:0] GEN_A_RESET = 31'd1;
    localparam logic [30:0] GEN_B_RESET = 31'd123456789;

    // Moduli are 2^31 - c, so a high part folds back in multiplied by c
    localparam logic [7:0]  FOLD_A  = 8'(32'h8000_0000 - MOD_A);
    localparam logic [7:0]  FOLD_B  = 8'(32'h8000_0000 - MOD_B);

    // Largest output value
    localparam logic [30:0] OUT_TOP = 31'(MOD_A - 32'd1);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_seed;  // load both generators with the seed
        logic mul_en;     // register generator products and quotient estimate
        logic fold_en;    // register first fold and slot remainder
        logic fin_en;     // commit the new first generator
        logic step_b;     // commit the new second generator
        logic warm_wr;    // write the warm-up value into the table
        logic set_prev;   // previous output takes the last warm-up value
        logic rd_en;      // read the chosen table slot
        logic out_en;     // combine, refill the slot, load the output register
    } t_dp_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic out_free;   // output register can take a beat this cycle
    } t_dp_sts;

endpackage

// File: hw/rtl/crng_lcg.sv
// One multiplicative congruential step modulo 2^31 - c, over two registered stages.
module crng_lcg import crng_pkg::*; (
    input  logic                i_clk,
    input  logic                i_mul_en,
    input  logic                i_fold_en,
    input  logic [WORD_W-1:0]   i_z,
    input  logic [15:0]         i_mul,
    input  logic [7:0]          i_fold,
    output logic [WORD_W-1:0]   o_res
);

    logic [46:0] r_prod;
    logic [31:0] r_v1;
    logic [23:0] hi_fold;
    logic [31:0] v1;
    logic [31:0] sum2;

    // Register the full product
    always_ff @(posedge i_clk) begin
        if (i_mul_en) begin
            r_prod <= {16'd0, i_z} * {31'd0, i_mul};
        end
    end

    // Fold the bits above 2^31 back in once
    assign hi_fold = {8'd0, r_prod[46:31]} * {16'd0, i_fold};
    assign v1      = {1'b0, r_prod[30:0]} + {8'd0, hi_fold};

    always_ff @(posedge i_clk) begin
        if (i_fold_en) begin
            r_v1 <= v1;
        end
    end

    // Second fold and final reduction: a carry out of lo + c means lo >= modulus
    assign sum2  = {1'b0, r_v1[30:0]} + {24'd0, i_fold};
    assign o_res = (r_v1[31] || sum2[31]) ? sum2[30:0] : r_v1[30:0];

endmodule

// File: hw/rtl/crng_ctrl.sv
// Sequencing controller for seeding, warm-up and draws.
module crng_ctrl import crng_pkg::*; #(
    parameter int unsigned TABLE_DEPTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic                            i_func,
    output logic                            o_stall,
    input  t_dp_sts                         i_sts,
    output t_dp_cmd                         o_cmd,
    output logic [$clog2(TABLE_DEPTH)-1:0]  o_wr_idx
);

    localparam int unsigned SW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 8);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_FOLD = 5'b00100,
        S_FIN  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state          r_state, n_state;
    logic            r_warm,  n_warm;
    logic [CW-1:0]   r_cnt,   n_cnt;

    assign o_stall  = (r_state != S_IDLE);
    assign o_wr_idx = r_cnt[SW-1:0];

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_warm  = r_warm;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_func == FUNC_RESEED) begin
                        o_cmd.load_seed = 1'b1;
                        n_warm          = 1'b1;
                        n_cnt           = CW'(TABLE_DEPTH + 7);
                    end
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul_en = 1'b1;
                n_state      = S_FOLD;
            end
            S_FOLD: begin
                o_cmd.fold_en = 1'b1;
                n_state       = S_FIN;
            end
            S_FIN: begin
                o_cmd.fin_en = 1'b1;
                if (r_warm) begin
                    o_cmd.warm_wr  = (r_cnt < CW'(TABLE_DEPTH));
                    o_cmd.set_prev = (r_cnt == '0);
                    if (r_cnt == '0) begin
                        n_warm = 1'b0;
                    end else begin
                        n_cnt = r_cnt - CW'(1);
                    end
                    n_state = S_MUL;
                end else begin
                    o_cmd.step_b = 1'b1;
                    o_cmd.rd_en  = 1'b1;
                    n_state      = S_OUT;
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_en = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_warm  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_warm  <= n_warm;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// File: hw/rtl/crng_dp.sv
// Datapath: generator states, slot selection, shuffle table and output register.
module crng_dp import crng_pkg::*; #(
    parameter int unsigned TABLE_DEPTH = 32
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  t_dp_cmd                         i_cmd,
    input  logic [$clog2(TABLE_DEPTH)-1:0]  i_wr_idx,
    input  logic [WORD_W-1:0]               i_seed_value,
    input  logic                            i_stall,
    output t_dp_sts                         o_sts,
    output logic                            o_valid,
    output logic [WORD_W-1:0]               o_random_value
);

    localparam int unsigned SW = $clog2(TABLE_DEPTH);
    localparam int unsigned QW = SW + 1;
    localparam logic [30:0] SLOT_SPAN =
        31'({1'b0, OUT_TOP} / 32'(TABLE_DEPTH) + 32'd1);
    // Reciprocal estimate never exceeds the true quotient by more than one short
    localparam logic [QW-1:0] RECIP   = QW'((64'd1 << 31) / {33'd0, SLOT_SPAN});
    localparam logic [QW:0]   DEPTH_Q = (QW+1)'(TABLE_DEPTH);

    logic [30:0]        r_gen_a, r_gen_b, r_prev;
    logic [QW-1:0]      r_q0;
    logic [31:0]        r_rem;
    logic [SW-1:0]      r_slot;
    logic [30:0]        r_rd;
    logic               r_rd_ok;
    logic [30:0]        r_table [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_vld;
    logic               r_out_valid;
    logic [30:0]        r_out_value;

    logic [30:0]        res_a, res_b, seed_eff;
    logic [30+QW:0]     q_prod, s_prod, rem_full;
    logic [QW:0]        q_fix;
    logic [SW-1:0]      slot;
    logic               wr_en;
    logic [SW-1:0]      wr_addr;
    logic [30:0]        wr_data, rd_eff, y;
    logic [31:0]        y_sum;

    // Generator step units
    crng_lcg u_lcg_a (
        .i_clk     (i_clk),
        .i_mul_en  (i_cmd.mul_en),
        .i_fold_en (i_cmd.fold_en),
        .i_z       (r_gen_a),
        .i_mul     (MUL_A),
        .i_fold    (FOLD_A),
        .o_res     (res_a)
    );

    crng_lcg u_lcg_b (
        .i_clk     (i_clk),
        .i_mul_en  (i_cmd.mul_en),
        .i_fold_en (i_cmd.fold_en),
        .i_z       (r_gen_b),
        .i_mul     (MUL_B),
        .i_fold    (FOLD_B),
        .o_res     (res_b)
    );

    assign seed_eff = (i_seed_value == '0) ? 31'd1 : i_seed_value;

    // Slot index: estimate, remainder, then correct by one and saturate
    assign q_prod   = {QW'(0), r_prev} * {31'd0, RECIP};
    assign s_prod   = {31'd0, r_q0} * {QW'(0), SLOT_SPAN};
    assign rem_full = {QW'(0), r_prev} - s_prod;
    assign q_fix    = {1'b0, r_q0} + (QW+1)'(r_rem >= {1'b0, SLOT_SPAN});
    assign slot     = (q_fix >= DEPTH_Q) ? SW'(TABLE_DEPTH - 1) : q_fix[SW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_q0 <= q_prod[30+QW:31];
        end
        if (i_cmd.fold_en) begin
            r_rem <= rem_full[31:0];
        end
        if (i_cmd.rd_en) begin
            r_slot <= slot;
        end
    end

    // Combine the slot with the second generator, wrapping into 1..OUT_TOP
    assign rd_eff = r_rd_ok ? r_rd : '0;
    assign y_sum  = {1'b0, rd_eff} - {1'b0, r_gen_b}
                  + ((rd_eff > r_gen_b) ? 32'd0 : {1'b0, OUT_TOP});
    assign y      = y_sum[30:0];

    // Generator and previous output state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen_a <= GEN_A_RESET;
            r_gen_b <= GEN_B_RESET;
            r_prev  <= '0;
        end else begin
            if (i_cmd.load_seed) begin
                r_gen_a <= seed_eff;
                r_gen_b <= seed_eff;
            end else if (i_cmd.fin_en) begin
                r_gen_a <= res_a;
                if (i_cmd.step_b) begin
                    r_gen_b <= res_b;
                end
            end
            if (i_cmd.set_prev) begin
                r_prev <= res_a;
            end else if (i_cmd.out_en) begin
                r_prev <= y;
            end
        end
    end

    // Shuffle table: one write port, one registered read port
    assign wr_en   = i_cmd.warm_wr | i_cmd.out_en;
    assign wr_addr = i_cmd.out_en ? r_slot  : i_wr_idx;
    assign wr_data = i_cmd.out_en ? r_gen_a : res_a;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_table[wr_addr] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd <= r_table[slot];
        end
    end

    // Entry written flags; an unwritten entry reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (i_cmd.rd_en) begin
                r_rd_ok <= r_vld[slot];
            end
        end
    end

    // Output register: load a beat, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_en) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_en) begin
            r_out_value <= y;
        end
    end

    assign o_sts.out_free = !r_out_valid || !i_stall;
    assign o_valid        = r_out_valid;
    assign o_random_value = r_out_value;

endmodule

// File: hw/rtl/combined_lcg_shuffle_rng.sv
// A draw steps through the multiply, fold, finish and output states before its result is registered,
// and the input is stalled until the controller is idle again. A reseed beat adds TABLE_DEPTH + 8
// warm-up steps, each one pass through the same multiply, fold and reduce stages that a draw uses.
// The input side takes the next beat while a finished result waits in the output register.
// Reset (synchronous, active low): generators to 1 and 123456789, previous output to zero,
// table entry flags cleared so every entry reads zero; no clearing pass is needed.
module combined_lcg_shuffle_rng import crng_pkg::*; #(
    parameter int unsigned TABLE_DEPTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_func,
    input  logic [WORD_W-1:0]   i_seed_value,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [WORD_W-1:0]   o_random_value
);

    localparam int unsigned SW = $clog2(TABLE_DEPTH);

    t_dp_cmd        cmd;
    t_dp_sts        sts;
    logic [SW-1:0]  wr_idx;

    // Sequencer
    crng_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_func   (i_func),
        .o_stall  (o_stall),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_wr_idx (wr_idx)
    );

    // Arithmetic, table and output register
    crng_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_wr_idx       (wr_idx),
        .i_seed_value   (i_seed_value),
        .i_stall        (i_stall),
        .o_sts          (sts),
        .o_valid        (o_valid),
        .o_random_value (o_random_value)
    );

endmodule

// File: test/tb.sv
// Self-checking testbench for the combined LCG shuffle random number generator.
module tb import crng_pkg::*;;

    localparam int unsigned TABLE_DEPTH  = 32;
    localparam longint unsigned SLOT_SPAN = 1 + longint'(OUT_TOP) / TABLE_DEPTH;
    localparam int unsigned RANDOM_BEATS = 1420;
    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned DRAIN_CYCLES = 30;

    typedef struct {
        logic              func;
        logic [WORD_W-1:0] seed;
        int unsigned       gap;
    } t_gen_request;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_stall;
    logic              i_func = 1'b0;
    logic [WORD_W-1:0] i_seed_value = '0;
    logic              o_valid;
    logic              i_stall = 1'b0;
    logic [WORD_W-1:0] o_random_value;

    // Predicted generator state
    logic [WORD_W-1:0] gen_a;
    logic [WORD_W-1:0] gen_b;
    logic [WORD_W-1:0] last_number;
    logic [WORD_W-1:0] shuffle_slots [TABLE_DEPTH];

    t_gen_request      pending_requests [$];
    logic [WORD_W-1:0] awaited_numbers [$];
    t_gen_request      staged_request;
    bit                staged = 1'b0;
    int unsigned       gap_left = 0;
    int unsigned       stall_left = 0;
    int unsigned       requests_taken = 0;
    int unsigned       requests_total = 0;
    int unsigned       error_count = 0;
    int unsigned       cycle_count = 0;
    bit                tx_quiet = 1'b0;
    bit                rx_quiet = 1'b0;

    combined_lcg_shuffle_rng #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_func         (i_func),
        .i_seed_value   (i_seed_value),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_random_value (o_random_value)
    );

    always #6 i_clk = ~i_clk;

    // Exact product modulo a generator modulus
    function automatic logic [WORD_W-1:0] mod_mul(input logic [WORD_W-1:0] z,
                                                  input logic [15:0] mul,
                                                  input logic [31:0] modulus);
        logic [63:0] prod;
        prod = 64'(z) * 64'(mul);
        return WORD_W'(prod % 64'(modulus));
    endfunction

    // Wait length for one beat; quiet stretches never idle
    function automatic int unsigned pick_wait(input bit quiet);
        if (quiet || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 10);
    endfunction

    // Step the predicted generator for one accepted beat and queue its number
    task automatic predict_number(input logic func, input logic [WORD_W-1:0] seed);
        logic [WORD_W-1:0] start;
        longint            combined;
        longint unsigned   slot;
        if (func == FUNC_RESEED) begin
            start = (seed == '0) ? WORD_W'(1) : seed;
            gen_a = start;
            gen_b = start;
            for (int j = TABLE_DEPTH + 7; j >= 0; j--) begin
                gen_a = mod_mul(gen_a, MUL_A, MOD_A);
                if (j < TABLE_DEPTH)
                    shuffle_slots[j] = gen_a;
            end
            last_number = shuffle_slots[0];
        end
        gen_a = mod_mul(gen_a, MUL_A, MOD_A);
        gen_b = mod_mul(gen_b, MUL_B, MOD_B);
        slot = longint'(last_number) / SLOT_SPAN;
        if (slot >= TABLE_DEPTH)
            slot = TABLE_DEPTH - 1;
        combined = longint'(shuffle_slots[slot]) - longint'(gen_b);
        shuffle_slots[slot] = gen_a;
        if (combined < 1)
            combined += longint'(OUT_TOP);
        last_number = WORD_W'(combined);
        awaited_numbers.push_back(last_number);
    endtask

    // Queue one request with its leading gap
    task automatic add_request(input logic func, input logic [WORD_W-1:0] seed);
        t_gen_request req;
        if ($urandom_range(0, 39) == 0)
            tx_quiet = !tx_quiet;
        req.func = func;
        req.seed = seed;
        req.gap  = pick_wait(tx_quiet);
        pending_requests.push_back(req);
        requests_total++;
    endtask

    // Seeds: full range, small values, or just around the moduli
    function automatic logic [WORD_W-1:0] pick_seed();
        case ($urandom_range(0, 5))
            0: return WORD_W'($urandom_range(0, 1000));
            1: return WORD_W'($urandom_range(MOD_A - 8, 32'h7FFF_FFFF));
            2: return WORD_W'($urandom_range(MOD_B - 8, MOD_B + 8));
            default: return WORD_W'($urandom);
        endcase
    endfunction

    // Driver: present queued requests, predict each accepted beat
    always @(posedge i_clk) begin
        logic next_valid;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            staged = 1'b0;
            gap_left = 0;
        end else begin
            next_valid = i_valid;
            if (i_valid && !o_stall) begin
                predict_number(i_func, i_seed_value);
                requests_taken++;
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (!staged && pending_requests.size() > 0) begin
                    staged_request = pending_requests.pop_front();
                    staged = 1'b1;
                    gap_left = staged_request.gap;
                end
                if (staged) begin
                    if (gap_left == 0) begin
                        next_valid = 1'b1;
                        staged = 1'b0;
                        i_func <= staged_request.func;
                        i_seed_value <= staged_request.seed;
                    end else begin
                        gap_left--;
                    end
                end
            end
            i_valid <= next_valid;
        end
    end

    // Monitor: check each result beat, then hold off for a drawn number of cycles
    always @(posedge i_clk) begin
        int unsigned       next_left;
        logic [WORD_W-1:0] want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left = 0;
        end else begin
            next_left = stall_left;
            if (o_valid && !i_stall) begin
                if (awaited_numbers.size() == 0) begin
                    $error("random_value: no result expected, got %0d", o_random_value);
                    error_count++;
                end else begin
                    want = awaited_numbers.pop_front();
                    if (o_random_value !== want) begin
                        $error("random_value: expected %0d, got %0d", want, o_random_value);
                        error_count++;
                    end
                end
                if ($urandom_range(0, 39) == 0)
                    rx_quiet = !rx_quiet;
                next_left = pick_wait(rx_quiet);
            end else if (stall_left != 0) begin
                next_left = stall_left - 1;
            end
            stall_left = next_left;
            i_stall <= (next_left != 0);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("combined_lcg_shuffle_rng regression: fail");
            $finish;
        end
    end

    initial begin
        gen_a = GEN_A_RESET;
        gen_b = GEN_B_RESET;
        last_number = '0;
        foreach (shuffle_slots[k])
            shuffle_slots[k] = '0;

        // Draws from the reset state, seed field ignored
        add_request(FUNC_DRAW, '0);
        add_request(FUNC_DRAW, '1);
        add_request(FUNC_DRAW, 31'h2AAA_AAAA);
        // Zero seed acts as one, then the extremes of the seed field
        add_request(FUNC_RESEED, '0);
        add_request(FUNC_DRAW, 31'h5555_5555);
        add_request(FUNC_RESEED, 31'd1);
        add_request(FUNC_RESEED, '1);
        add_request(FUNC_DRAW, '0);
        // Seeds equal to a modulus pin that generator at zero
        add_request(FUNC_RESEED, WORD_W'(MOD_A));
        add_request(FUNC_DRAW, '0);
        add_request(FUNC_DRAW, '1);
        add_request(FUNC_RESEED, WORD_W'(MOD_B));
        add_request(FUNC_DRAW, '0);
        add_request(FUNC_DRAW, '0);
        // Seeds on either side of the moduli
        add_request(FUNC_RESEED, WORD_W'(MOD_A - 1));
        add_request(FUNC_RESEED, WORD_W'(MOD_A + 1));
        add_request(FUNC_RESEED, WORD_W'(MOD_B + 1));
        add_request(FUNC_RESEED, 31'd12345);
        add_request(FUNC_DRAW, '0);
        add_request(FUNC_DRAW, '0);
        add_request(FUNC_RESEED, 31'h5555_5555);
        add_request(FUNC_RESEED, 31'h2AAA_AAAA);
        add_request(FUNC_DRAW, '1);

        // Long runs of draws broken by occasional reseeds
        repeat (RANDOM_BEATS) begin
            if ($urandom_range(0, 15) == 0)
                add_request(FUNC_RESEED, pick_seed());
            else
                add_request(FUNC_DRAW, WORD_W'($urandom));
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (requests_taken < requests_total)
            @(posedge i_clk);
        while (awaited_numbers.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0)
            $display("combined_lcg_shuffle_rng regression: pass");
        else
            $display("combined_lcg_shuffle_rng regression: fail");
        $finish;
    end

endmodule
